@@ src/wsda_pkg.sv @@
// Package with types, sizes and codes shared by the waiting-slot dock arbiter.
`default_nettype none
package wsda_pkg;

  localparam int SLOTS   = 8;
  localparam int ID_BITS = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int OP_W    = 3;
  localparam int SIDX_W  = 3;
  localparam int CFG_W   = 4;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE  = 3'd0,
    OP_ADVANCE  = 3'd1,
    OP_APPROACH = 3'd2,
    OP_ENTER    = 3'd3,
    OP_EXIT     = 3'd4,
    OP_CANCEL   = 3'd5,
    OP_TICK     = 3'd6,
    OP_QUERY    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESERVE,
    ST_ADV_MOVE,
    ST_ADV_FREE,
    ST_FIND_MARK,
    ST_READY_CHK,
    ST_FIND_FREE,
    ST_CAN_LIST,
    ST_CAN_SLOT,
    ST_TICK_NEXT,
    ST_TICK_FIND,
    ST_TICK_REM,
    ST_STAT_APP,
    ST_STAT_PREV,
    ST_STAT_CUR,
    ST_DONE
  } state_e;

  // Configuration register indexes.
  localparam logic CFG_SLOTS_IN_USE   = 1'b0;
  localparam logic CFG_GRANT_DISABLED = 1'b1;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 4'd8;

endpackage
`default_nettype wire

@@ src/waiting_slot_dock_arbiter_top.sv @@
// Waiting-slot dock arbiter: slot row, ready list, holder and a scanning sequencer.
//
// Usage: one input beat (opcode, requester_id, slot_index) is taken when in_valid_i
// is high and in_stall_o is low; each input beat yields exactly one output beat
// carrying the status after the update. The configuration port writes slots_in_use
// (index 0) and grant_disabled (index 1) on any cycle with cfg_we_i high; write only
// while the block is idle.
// Sequencing: a small sequencer drives one shared compare unit that reads one slot
// (owner and reached mark) and one ready-list entry per cycle. Every item ends with a
// status pass that scans the usable slots; reserve and enter first scan the slots,
// approach scans the slots and then the ready list, cancel scans the ready list and
// then the slots, and a tick may do a slot scan for each ready entry. A new beat is
// not taken until the current item is done: the result beat is loaded into the output
// register as the sequencer returns to idle, and in_stall_o stays high until then.
// Reset clears all slots, the ready count, the holder and the inside flag, and sets
// slots_in_use to 8 and grant_disabled to 0. While the receiver stalls, the finished
// beat waits in the output register; the next item is still taken and worked on, and
// holds in its last state until the output register is free.
`default_nettype none
module waiting_slot_dock_arbiter_top
  import wsda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration port.
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  // Input channel.
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire id_t               requester_id_i,
  input  wire logic [SIDX_W-1:0] slot_index_i,
  // Output channel.
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic              ok_o,
  output      logic [SIDX_W-1:0] slot_o,
  output      logic              clear_to_approach_o,
  output      logic              clear_to_enter_o,
  output      logic              clear_to_advance_o,
  output      id_t               holder_id_o,
  output      logic              holder_inside_o,
  output      logic              granted_o,
  output      logic              exit_mismatch_o
);

  // Architectural state.
  id_t                owner_q [SLOTS];
  logic [SLOTS-1:0]   reached_q;
  id_t                list_q  [SLOTS];
  cnt_t               cnt_q, cnt_d;
  id_t                holder_q, holder_d;
  logic               inside_q, inside_d;
  logic [CFG_W-1:0]   siu_q;
  logic               gd_q;

  // Sequencer and item registers.
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  id_t                id_q, id_d;
  id_t                key_q, key_d;
  logic [SIDX_W-1:0]  idx_q, idx_d;
  cnt_t               sp_q, sp_d;
  cnt_t               lp_q, lp_d;
  cnt_t               wp_q, wp_d;
  logic               ok_q, ok_d;
  logic [SIDX_W-1:0]  slot_q, slot_d;
  logic               granted_q, granted_d;
  logic               mism_q, mism_d;
  logic               cta_q, cta_d;
  logic               ctadv_q, ctadv_d;

  // Output register.
  logic               out_valid_q;
  logic               out_load;

  // Shared read ports and write strobes.
  idx_t               sa, la, lw_addr;
  id_t                owner_rd, list_rd, lw_val, ow_val;
  logic               reached_rd, ow_en, rw_en, rw_val, lw_en;

  // Derived conditions.
  cnt_t               n_w, lp_nx;
  logic               in_acc, sp_end, lp_end, id_nz, free_rd, hit_id, hit_key, prev_ok;
  idx_t               idx_at, idx_prev;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Usable slot count; values above SLOTS act as SLOTS.
  assign n_w      = (int'(siu_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(siu_q);
  assign sp_end   = (sp_q >= n_w);
  assign lp_end   = (lp_q >= cnt_q);
  assign lp_nx    = lp_q + cnt_t'(1);
  assign id_nz    = (id_q != '0);
  assign idx_at   = IDX_W'(idx_q);
  assign idx_prev = IDX_W'(idx_q - SIDX_W'(1));

  // Slot read address: the neighbor pair for advance checks, else the scan pointer.
  always_comb begin
    case (state_q)
      ST_ADV_MOVE, ST_STAT_PREV: sa = idx_prev;
      ST_ADV_FREE, ST_STAT_CUR:  sa = idx_at;
      default:                   sa = sp_q[IDX_W-1:0];
    endcase
  end

  assign la         = (state_q == ST_TICK_REM) ? lp_nx[IDX_W-1:0] : lp_q[IDX_W-1:0];
  assign owner_rd   = owner_q[sa];
  assign reached_rd = reached_q[sa];
  assign list_rd    = list_q[la];

  // The shared compare unit.
  assign free_rd = (owner_rd == '0);
  assign hit_id  = (owner_rd == id_q);
  assign hit_key = (owner_rd == key_q);
  assign prev_ok = id_nz && (idx_q != '0) && (int'(idx_q) < int'(n_w)) && free_rd;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(opcode_i))
            OP_RESERVE:  state_d = (requester_id_i != '0) ? ST_RESERVE : ST_STAT_APP;
            OP_ADVANCE:  state_d = ST_ADV_MOVE;
            OP_APPROACH: state_d = (requester_id_i != '0) ? ST_FIND_MARK : ST_STAT_APP;
            OP_ENTER:    state_d = (requester_id_i != '0) ? ST_FIND_FREE : ST_STAT_APP;
            OP_CANCEL:   state_d = (requester_id_i != '0) ? ST_CAN_LIST : ST_STAT_APP;
            OP_TICK:     state_d = (holder_q == '0 && !gd_q) ? ST_TICK_NEXT : ST_STAT_APP;
            default:     state_d = ST_STAT_APP;
          endcase
        end
      end
      ST_RESERVE:   if (sp_end || hit_id || free_rd) state_d = ST_STAT_APP;
      ST_ADV_MOVE:  state_d = prev_ok ? ST_ADV_FREE : ST_STAT_APP;
      ST_ADV_FREE:  state_d = ST_STAT_APP;
      ST_FIND_MARK: begin
        if (sp_end) state_d = ST_STAT_APP;
        else if (hit_id) state_d = ST_READY_CHK;
      end
      ST_READY_CHK: if (lp_end || list_rd == id_q) state_d = ST_STAT_APP;
      ST_FIND_FREE: if (sp_end || hit_id) state_d = ST_STAT_APP;
      ST_CAN_LIST:  if (lp_end) state_d = ST_CAN_SLOT;
      ST_CAN_SLOT:  if (sp_end) state_d = ST_STAT_APP;
      ST_TICK_NEXT: state_d = lp_end ? ST_STAT_APP : ST_TICK_FIND;
      ST_TICK_FIND: begin
        if (sp_end) state_d = ST_TICK_NEXT;
        else if (hit_key) state_d = reached_rd ? ST_TICK_REM : ST_TICK_NEXT;
      end
      ST_TICK_REM:  if (!(lp_nx < cnt_q)) state_d = ST_STAT_APP;
      ST_STAT_APP:  if (sp_end || free_rd || hit_id) state_d = ST_STAT_PREV;
      ST_STAT_PREV: state_d = ST_STAT_CUR;
      ST_STAT_CUR:  state_d = ST_DONE;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Datapath control for each sequencer step.
  always_comb begin
    op_d      = op_q;
    id_d      = id_q;
    key_d     = key_q;
    idx_d     = idx_q;
    sp_d      = sp_q;
    lp_d      = lp_q;
    wp_d      = wp_q;
    ok_d      = ok_q;
    slot_d    = slot_q;
    granted_d = granted_q;
    mism_d    = mism_q;
    cta_d     = cta_q;
    ctadv_d   = ctadv_q;
    cnt_d     = cnt_q;
    holder_d  = holder_q;
    inside_d  = inside_q;
    ow_en     = 1'b0;
    ow_val    = '0;
    rw_en     = 1'b0;
    rw_val    = 1'b0;
    lw_en     = 1'b0;
    lw_addr   = lp_q[IDX_W-1:0];
    lw_val    = list_rd;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d      = op_e'(opcode_i);
          id_d      = requester_id_i;
          key_d     = requester_id_i;
          idx_d     = slot_index_i;
          sp_d      = '0;
          lp_d      = '0;
          wp_d      = '0;
          ok_d      = 1'b0;
          slot_d    = '0;
          granted_d = 1'b0;
          mism_d    = 1'b0;
          cta_d     = 1'b0;
          ctadv_d   = 1'b0;
          if (op_e'(opcode_i) == OP_ENTER) inside_d = 1'b1;
          if (op_e'(opcode_i) == OP_EXIT) begin
            inside_d = 1'b0;
            if (requester_id_i == holder_q) holder_d = '0;
            else mism_d = 1'b1;
          end
        end
      end
      ST_RESERVE: begin
        if (!sp_end) begin
          if (hit_id || free_rd) begin
            ow_en  = 1'b1;
            ow_val = id_q;
            ok_d   = 1'b1;
            slot_d = SIDX_W'(sp_q);
          end else begin
            sp_d = sp_q + cnt_t'(1);
          end
        end
      end
      ST_ADV_MOVE: begin
        if (prev_ok) begin
          ow_en  = 1'b1;
          ow_val = id_q;
          rw_en  = 1'b1;
          ok_d   = 1'b1;
          slot_d = idx_q - SIDX_W'(1);
        end
      end
      ST_ADV_FREE: begin
        ow_en = 1'b1;
        rw_en = 1'b1;
      end
      ST_FIND_MARK: begin
        if (!sp_end) begin
          if (hit_id) begin
            rw_en  = 1'b1;
            rw_val = 1'b1;
          end else begin
            sp_d = sp_q + cnt_t'(1);
          end
        end
      end
      ST_READY_CHK: begin
        // Append when the requester is neither listed nor holding, and room remains.
        if (lp_end) begin
          if (id_q != holder_q && int'(cnt_q) < SLOTS) begin
            lw_en   = 1'b1;
            lw_addr = cnt_q[IDX_W-1:0];
            lw_val  = id_q;
            cnt_d   = cnt_q + cnt_t'(1);
          end
        end else if (list_rd != id_q) begin
          lp_d = lp_q + cnt_t'(1);
        end
      end
      ST_FIND_FREE: begin
        if (!sp_end) begin
          if (hit_id) begin
            ow_en = 1'b1;
            rw_en = 1'b1;
          end else begin
            sp_d = sp_q + cnt_t'(1);
          end
        end
      end
      ST_CAN_LIST: begin
        // Compact the ready list, dropping every entry of the requester.
        if (!lp_end) begin
          if (list_rd != id_q) begin
            lw_en   = 1'b1;
            lw_addr = wp_q[IDX_W-1:0];
            wp_d    = wp_q + cnt_t'(1);
          end
          lp_d = lp_q + cnt_t'(1);
        end else begin
          cnt_d = wp_q;
        end
      end
      ST_CAN_SLOT: begin
        if (!sp_end) begin
          if (hit_id) begin
            ow_en = 1'b1;
            rw_en = 1'b1;
          end
          sp_d = sp_q + cnt_t'(1);
        end else if (holder_q == id_q) begin
          holder_d = '0;
          inside_d = 1'b0;
        end
      end
      ST_TICK_NEXT: begin
        if (!lp_end) begin
          key_d = list_rd;
          sp_d  = '0;
        end
      end
      ST_TICK_FIND: begin
        if (sp_end) begin
          lp_d = lp_q + cnt_t'(1);
        end else if (hit_key) begin
          if (reached_rd) begin
            holder_d  = key_q;
            granted_d = 1'b1;
          end else begin
            lp_d = lp_q + cnt_t'(1);
          end
        end else begin
          sp_d = sp_q + cnt_t'(1);
        end
      end
      ST_TICK_REM: begin
        // Shift the tail of the ready list down over the granted entry.
        if (lp_nx < cnt_q) begin
          lw_en = 1'b1;
          lp_d  = lp_nx;
        end else begin
          cnt_d = cnt_q - cnt_t'(1);
        end
      end
      ST_STAT_APP: begin
        if (!sp_end) begin
          if (free_rd || hit_id) cta_d = 1'b1;
          else sp_d = sp_q + cnt_t'(1);
        end
      end
      ST_STAT_PREV: ctadv_d = prev_ok;
      ST_STAT_CUR:  ctadv_d = ctadv_q && hit_id && reached_rd;
      default: ;
    endcase
    // Every status pass starts its slot scan from the bottom.
    if (state_d == ST_STAT_APP && state_q != ST_STAT_APP) sp_d = '0;
  end

  // Control and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reached_q   <= '0;
      cnt_q       <= '0;
      holder_q    <= '0;
      inside_q    <= 1'b0;
      siu_q       <= SLOTS_IN_USE_RST;
      gd_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) owner_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      holder_q <= holder_d;
      inside_q <= inside_d;
      if (ow_en) owner_q[sa] <= ow_val;
      if (rw_en) reached_q[sa] <= rw_val;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOTS_IN_USE:   siu_q <= cfg_wdata_i;
          CFG_GRANT_DISABLED: gd_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    sp_q      <= sp_d;
    lp_q      <= lp_d;
    wp_q      <= wp_d;
    ok_q      <= ok_d;
    slot_q    <= slot_d;
    granted_q <= granted_d;
    mism_q    <= mism_d;
    cta_q     <= cta_d;
    ctadv_q   <= ctadv_d;
    if (lw_en) list_q[lw_addr] <= lw_val;
    if (out_load) begin
      ok_o                <= ok_q;
      slot_o              <= slot_q;
      clear_to_approach_o <= cta_q;
      clear_to_enter_o    <= id_nz && (id_q == holder_q);
      clear_to_advance_o  <= ctadv_q;
      holder_id_o         <= holder_q;
      holder_inside_o     <= inside_q;
      granted_o           <= granted_q && (op_q == OP_TICK);
      exit_mismatch_o     <= mism_q && (op_q == OP_EXIT);
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks on the sequencer and the results.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= SLOTS) else $error("ready count beyond slot count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE)) else $error("accepted item left no work");

  a_grant_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (holder_id_o != '0)) else $error("grant without holder");

  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (slot_o == '0)) else $error("slot reported on failure");

  a_mism_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && exit_mismatch_o) |-> !holder_inside_o)
    else $error("inside flag kept after exit");

endmodule
`default_nettype wire
